>>> hw/rtl/fixed_point_q24_8_alu_top_macros.svh
// assertion macros used by the alu top
`ifndef FIXED_POINT_Q24_8_ALU_TOP_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_MACROS_SVH

// same-cycle implication checked on every clock edge outside reset
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fpa_pkg.sv
// shared constants and operation codes for the fixed point alu
package fpa_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int KIND_W         = 4;

  // operation codes carried in tuser
  typedef enum logic [KIND_W-1:0] {
    K_ADD = 4'd0,
    K_SUB = 4'd1,
    K_MUL = 4'd2,
    K_DIV = 4'd3,
    K_MIN = 4'd4,
    K_MAX = 4'd5,
    K_INC = 4'd6,
    K_DEC = 4'd7,
    K_I2F = 4'd8,
    K_F2I = 4'd9
  } kind_t;

endpackage

>>> hw/rtl/fixed_point_q24_8_alu_top.sv
// Throughput: one item per cycle while the output is not stalled.
// The depth is set by the divider, one quotient bit per stage.
// All operations share that depth, so results leave in input order.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits only; data registers keep their contents.
module fixed_point_q24_8_alu_top #(
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // operand_a, operand_b
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   in_tdata,
  // kind
  input  logic [fpa_pkg::KIND_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result, a_greater, a_less, a_equal, divide_by_zero, overflow
  output logic [((DATA_WIDTH+5+7)/8)*8-1:0]   out_tdata
);
  import fpa_pkg::*;

  `include "fixed_point_q24_8_alu_top_macros.svh"

  localparam int NUMW  = DATA_WIDTH + FRAC_BITS;
  localparam int LD    = NUMW + 1;
  localparam int MD    = LD - 3;
  localparam int OUT_W = ((DATA_WIDTH + 5 + 7) / 8) * 8;
  localparam int MW    = 2 * DATA_WIDTH;
  localparam int QW    = NUMW + 1;

  typedef struct packed {
    kind_t                 kind;
    logic                  gt;
    logic                  lt;
    logic                  eq;
    logic                  dbz;
    logic                  negp;
    logic [DATA_WIDTH-1:0] res;
    logic                  ovf;
  } side_t;

  logic                          adv;
  logic signed [DATA_WIDTH-1:0]  a;
  logic signed [DATA_WIDTH-1:0]  b;
  kind_t                         kind;
  side_t                         s1_nxt;
  side_t                         s1_r;
  logic                          v1_r;
  logic [DATA_WIDTH-1:0]         amag_r;
  logic [DATA_WIDTH-1:0]         bmag_r;
  logic [DATA_WIDTH:0]           add_w;
  logic [DATA_WIDTH:0]           sub_w;
  logic [DATA_WIDTH:0]           inc_w;
  logic [DATA_WIDTH:0]           dec_w;
  logic [NUMW-1:0]               i2f_w;
  logic [DATA_WIDTH-1:0]         max_v;
  logic [DATA_WIDTH-1:0]         min_v;
  side_t                         side_r [LD];
  logic [LD-1:0]                 v_r;
  logic [MW-1:0]                 mmag;
  logic [MW-1:0]                 mdly_r [MD];
  logic [QW-1:0]                 quo;
  logic [DATA_WIDTH-1:0]         res_nxt;
  logic                          ovf_nxt;
  logic [DATA_WIDTH-1:0]         res_r;
  logic                          ovf_r;
  side_t                         so;
  logic                          out_valid_r;
  logic [MW-1:0]                 mm;
  logic [QW-1:0]                 qm;

  // whole pipeline moves together unless a result waits
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign a    = in_tdata[DATA_WIDTH-1:0];
  assign b    = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign kind = kind_t'(in_tuser);
  assign max_v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  assign min_v = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // first stage: compare, single-add, min/max and shift operations, magnitudes
  always_comb begin
    add_w = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    sub_w = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    inc_w = {a[DATA_WIDTH-1], a} + (DATA_WIDTH+1)'(1);
    dec_w = {a[DATA_WIDTH-1], a} - (DATA_WIDTH+1)'(1);
    i2f_w = {a, {FRAC_BITS{1'b0}}};
    s1_nxt      = '0;
    s1_nxt.kind = kind;
    s1_nxt.gt   = a > b;
    s1_nxt.lt   = a < b;
    s1_nxt.eq   = a == b;
    s1_nxt.negp = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    case (kind)
      K_ADD: begin
        s1_nxt.ovf = add_w[DATA_WIDTH] != add_w[DATA_WIDTH-1];
        s1_nxt.res = s1_nxt.ovf ? (add_w[DATA_WIDTH] ? min_v : max_v)
                                : add_w[DATA_WIDTH-1:0];
      end
      K_SUB: begin
        s1_nxt.ovf = sub_w[DATA_WIDTH] != sub_w[DATA_WIDTH-1];
        s1_nxt.res = s1_nxt.ovf ? (sub_w[DATA_WIDTH] ? min_v : max_v)
                                : sub_w[DATA_WIDTH-1:0];
      end
      K_INC: begin
        s1_nxt.ovf = inc_w[DATA_WIDTH] != inc_w[DATA_WIDTH-1];
        s1_nxt.res = s1_nxt.ovf ? max_v : inc_w[DATA_WIDTH-1:0];
      end
      K_DEC: begin
        s1_nxt.ovf = dec_w[DATA_WIDTH] != dec_w[DATA_WIDTH-1];
        s1_nxt.res = s1_nxt.ovf ? min_v : dec_w[DATA_WIDTH-1:0];
      end
      K_MIN: s1_nxt.res = (a < b) ? a : b;
      K_MAX: s1_nxt.res = (a > b) ? a : b;
      K_I2F: begin
        s1_nxt.ovf = !((&i2f_w[NUMW-1:DATA_WIDTH-1]) || !(|i2f_w[NUMW-1:DATA_WIDTH-1]));
        s1_nxt.res = s1_nxt.ovf ? (a[DATA_WIDTH-1] ? min_v : max_v)
                                : i2f_w[DATA_WIDTH-1:0];
      end
      K_F2I: s1_nxt.res = DATA_WIDTH'(a >>> FRAC_BITS);
      K_DIV: s1_nxt.dbz = b == '0;
      default: s1_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      amag_r <= a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
      bmag_r <= b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
    end
  end

  // long arithmetic units
  fpa_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .en    (adv),
    .a_mag (amag_r),
    .b_mag (bmag_r),
    .mag_o (mmag)
  );

  fpa_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .en    (adv),
    .num_i ({amag_r, {FRAC_BITS{1'b0}}}),
    .den_i (bmag_r),
    .quo_o (quo)
  );

  // side info and product ride alongside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LD-2:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= s1_r;
      for (int i = 1; i < LD; i++) begin
        side_r[i] <= side_r[i-1];
      end
      mdly_r[0] <= mmag;
      for (int i = 1; i < MD; i++) begin
        mdly_r[i] <= mdly_r[i-1];
      end
    end
  end

  // final stage: pick the result and saturate signed magnitudes
  always_comb begin
    so      = side_r[LD-1];
    mm      = mdly_r[MD-1];
    qm      = quo;
    res_nxt = so.res;
    ovf_nxt = so.ovf;
    case (so.kind)
      K_MUL: begin
        ovf_nxt = so.negp ? (mm > (MW'(1) << (DATA_WIDTH - 1)))
                          : (mm > ((MW'(1) << (DATA_WIDTH - 1)) - MW'(1)));
        res_nxt = ovf_nxt ? (so.negp ? min_v : max_v)
                          : (so.negp ? DATA_WIDTH'(-mm) : DATA_WIDTH'(mm));
      end
      K_DIV: begin
        if (so.dbz) begin
          ovf_nxt = 1'b0;
          res_nxt = '0;
        end else begin
          ovf_nxt = so.negp ? (qm > (QW'(1) << (DATA_WIDTH - 1)))
                            : (qm > ((QW'(1) << (DATA_WIDTH - 1)) - QW'(1)));
          res_nxt = ovf_nxt ? (so.negp ? min_v : max_v)
                            : (so.negp ? DATA_WIDTH'(-qm) : DATA_WIDTH'(qm));
        end
      end
      default: begin
        res_nxt = so.res;
        ovf_nxt = so.ovf;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[LD-1];
    end
  end

  side_t out_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r      <= res_nxt;
      ovf_r      <= ovf_nxt;
      out_side_r <= so;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({ovf_r, out_side_r.dbz, out_side_r.eq, out_side_r.lt,
                              out_side_r.gt, res_r});

  // checks on the pipeline
  `FPA_ASSERT_NOW(a_dbz_zero, out_tvalid && out_side_r.dbz, res_r == '0 && !ovf_r, "dbz with nonzero result")
  `FPA_ASSERT_NOW(a_cmp_onehot, out_tvalid, $onehot({out_side_r.gt, out_side_r.lt, out_side_r.eq}), "compare flags not one-hot")
  `FPA_ASSERT_NOW(a_stall_hold, out_tvalid && !out_tready, !in_tready, "input taken during output stall")

endmodule

>>> hw/rtl/fpa_mul.sv
// three stage magnitude multiplier with round half up on the fraction bits
module fpa_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DATA_WIDTH-1:0]     a_mag,
  input  logic [DATA_WIDTH-1:0]     b_mag,
  output logic [2*DATA_WIDTH-1:0]   mag_o
);
  import fpa_pkg::*;

  localparam int HL = DATA_WIDTH / 2;
  localparam int HH = DATA_WIDTH - HL;
  localparam int PW = 2 * DATA_WIDTH;

  logic [2*HL-1:0]  pp0_r;
  logic [HL+HH-1:0] pp1_r;
  logic [HL+HH-1:0] pp2_r;
  logic [2*HH-1:0]  pp3_r;
  logic [PW-1:0]    sum_r;
  logic [PW-1:0]    mag_r;
  logic [PW-1:0]    sum_nxt;
  logic [PW-1:0]    mag_nxt;

  // partial products of the split magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r <= a_mag[HL-1:0] * b_mag[HL-1:0];
      pp1_r <= a_mag[HL-1:0] * b_mag[DATA_WIDTH-1:HL];
      pp2_r <= a_mag[DATA_WIDTH-1:HL] * b_mag[HL-1:0];
      pp3_r <= a_mag[DATA_WIDTH-1:HL] * b_mag[DATA_WIDTH-1:HL];
    end
  end

  // sum the partial products, then add half an lsb and drop the fraction
  always_comb begin
    sum_nxt = PW'(pp0_r) + ((PW'(pp1_r) + PW'(pp2_r)) << HL) + (PW'(pp3_r) << (2 * HL));
    mag_nxt = (sum_r + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign mag_o = mag_r;

endmodule

>>> hw/rtl/fpa_div.sv
// pipelined restoring divider, one quotient bit per stage, then rounding
module fpa_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [DATA_WIDTH+FRAC_BITS-1:0]   num_i,
  input  logic [DATA_WIDTH-1:0]             den_i,
  output logic [DATA_WIDTH+FRAC_BITS:0]     quo_o
);
  import fpa_pkg::*;

  localparam int NUMW = DATA_WIDTH + FRAC_BITS;

  logic [DATA_WIDTH-1:0] rem_r [NUMW];
  logic [NUMW-1:0]       num_r [NUMW];
  logic [NUMW-1:0]       q_r   [NUMW];
  logic [DATA_WIDTH-1:0] den_r [NUMW];
  logic [NUMW:0]         quo_r;
  logic [NUMW:0]         quo_nxt;

  // one shift, compare and subtract per stage
  for (genvar i = 0; i < NUMW; i++) begin : g_stage
    logic [DATA_WIDTH-1:0] rem_in;
    logic [NUMW-1:0]       num_in;
    logic [NUMW-1:0]       q_in;
    logic [DATA_WIDTH-1:0] den_in;
    logic [DATA_WIDTH:0]   trial;
    logic                  ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign q_in   = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign q_in   = q_r[i-1];
      assign den_in = den_r[i-1];
    end

    assign trial = {rem_in, num_in[NUMW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DATA_WIDTH'(trial - {1'b0, den_in}) : DATA_WIDTH'(trial);
        num_r[i] <= num_in << 1;
        q_r[i]   <= {q_in[NUMW-2:0], ge};
        den_r[i] <= den_in;
      end
    end
  end

  // round half away from zero on the remainder
  always_comb begin
    quo_nxt = {1'b0, q_r[NUMW-1]}
            + (NUMW+1)'(rem_r[NUMW-1] >= (den_r[NUMW-1] - rem_r[NUMW-1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo_o = quo_r;

endmodule

>>> bench/fixed_point_q24_8_alu_top_test.sv
// self-checking bench for the q24.8 fixed point alu stream block
module fixed_point_q24_8_alu_top_test;
  import fpa_pkg::*;

  localparam int DW = 32;
  localparam int FB = 8;
  localparam int LATENCY = DW + FB + 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1500;

  typedef struct packed {
    logic            ovf;
    logic            dbz;
    logic            eq;
    logic            lt;
    logic            gt;
    logic [DW-1:0]   value;
  } alu_res_t;

  typedef struct {
    logic [3:0]      op;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    logic            known;
    alu_res_t        res;
  } vec_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;   // operand_a, operand_b
  logic [3:0] in_tuser;    // kind
  logic out_tvalid;
  logic out_tready;
  logic [39:0] out_tdata;  // result, a_greater, a_less, a_equal, divide_by_zero, overflow

  alu_res_t expected_q[$];
  int mismatches;
  int idle_cycles;
  bit sender_done;

  fixed_point_q24_8_alu_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // saturate a wide signed value to the data width
  function automatic logic [DW-1:0] clamp(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[DW-1:0];
  endfunction

  // exact alu prediction: rounding half away from zero on mul and div
  function automatic alu_res_t alu_predict(input logic [3:0] op, input logic [DW-1:0] ra,
                                           input logic [DW-1:0] rb);
    alu_res_t r;
    logic signed [127:0] a, b, m, q, d, rm;
    logic ovf;
    logic neg;
    a = $signed(ra);
    b = $signed(rb);
    ovf = 1'b0;
    r = '0;
    neg = (a < 0) != (b < 0);
    case (op)
      K_ADD: r.value = clamp(a + b, ovf);
      K_SUB: r.value = clamp(a - b, ovf);
      K_MUL: begin
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (1 << (FB - 1))) >>> FB;
        r.value = clamp(neg ? -m : m, ovf);
      end
      K_DIV: begin
        if (b == 0) r.dbz = 1'b1;
        else begin
          d = b < 0 ? -b : b;
          m = (a < 0 ? -a : a) <<< FB;
          q = m / d;
          rm = m % d;
          if (rm >= d - rm) q = q + 1;
          r.value = clamp(neg ? -q : q, ovf);
        end
      end
      K_MIN: r.value = (a < b) ? ra : rb;
      K_MAX: r.value = (a > b) ? ra : rb;
      K_INC: r.value = clamp(a + 1, ovf);
      K_DEC: r.value = clamp(a - 1, ovf);
      K_I2F: r.value = clamp(a <<< FB, ovf);
      K_F2I: r.value = $signed(ra) >>> FB;
      default: r.value = '0;
    endcase
    r.gt = a > b;
    r.lt = a < b;
    r.eq = a == b;
    r.ovf = ovf;
    return r;
  endfunction

  // directed rows; known results typed only for the obvious ones
  vec_t directed[$];

  task automatic add_row(input logic [3:0] op, input logic [DW-1:0] a, input logic [DW-1:0] b,
                         input logic known, input logic [DW-1:0] v, input logic [4:0] fl);
    vec_t t;
    t.op = op; t.a = a; t.b = b; t.known = known;
    t.res = {fl[0], fl[1], fl[2], fl[3], fl[4], v};
    directed.push_back(t);
  endtask

  // random operand: extremes, zero, small or medium values, or full range
  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff - $urandom_range(0, 2);
      1: return 32'h80000000 + $urandom_range(0, 2);
      2, 3: return $urandom_range(0, 4095) - 2048;
      4: return '0;
      5: return $urandom_range(0, 1 << 20) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [3:0] op, input logic [DW-1:0] a, input logic [DW-1:0] b,
                      input logic long_gaps);
    int gap;
    gap = long_gaps ? ($urandom_range(0, 19) == 0 ? $urandom_range(5, 60) : $urandom_range(0, 2))
                    : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stimulus process
  initial begin
    logic [3:0] op;
    logic [DW-1:0] a, b;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    sender_done = 1'b0;
    // flags order: gt lt eq dbz ovf
    add_row(K_ADD, 32'h7fffffff, 32'h1, 1, 32'h7fffffff, 5'b10001);
    add_row(K_ADD, 32'h80000000, 32'hffffffff, 1, 32'h80000000, 5'b01001);
    add_row(K_SUB, 32'h80000000, 32'h1, 1, 32'h80000000, 5'b01001);
    add_row(K_SUB, 32'h7fffffff, 32'hffffffff, 1, 32'h7fffffff, 5'b10001);
    add_row(K_MUL, 32'h7fffffff, 32'h7fffffff, 1, 32'h7fffffff, 5'b00101);
    add_row(K_MUL, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, 5'b01001);
    add_row(K_MUL, 32'h00000180, 32'hffffff80, 0, '0, '0);
    add_row(K_MUL, 32'h00000001, 32'h00000080, 0, '0, '0);
    add_row(K_MUL, 32'hffffffff, 32'h00000080, 0, '0, '0);
    add_row(K_DIV, 32'h00000100, 32'h0, 1, 32'h0, 5'b10010);
    add_row(K_DIV, 32'h80000000, 32'h0, 1, 32'h0, 5'b01010);
    add_row(K_DIV, 32'h7fffffff, 32'h00000001, 1, 32'h7fffffff, 5'b10001);
    add_row(K_DIV, 32'h00000001, 32'h00000200, 0, '0, '0);
    add_row(K_DIV, 32'h80000000, 32'hffffffff, 0, '0, '0);
    add_row(K_MIN, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, 5'b01000);
    add_row(K_MAX, 32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 5'b01000);
    add_row(K_INC, 32'h7fffffff, 32'h7fffffff, 1, 32'h7fffffff, 5'b00101);
    add_row(K_DEC, 32'h80000000, 32'h80000000, 1, 32'h80000000, 5'b00101);
    add_row(K_I2F, 32'h00800000, 32'h0, 1, 32'h7fffffff, 5'b10001);
    add_row(K_I2F, 32'hff800000, 32'h0, 1, 32'h80000000, 5'b01000);
    add_row(K_I2F, 32'hff7fffff, 32'h0, 1, 32'h80000000, 5'b01001);
    add_row(K_F2I, 32'hffffffff, 32'h0, 1, 32'hffffffff, 5'b01000);
    add_row(K_F2I, 32'h80000000, 32'h0, 1, 32'hff800000, 5'b01000);
    add_row(4'd10, 32'h00000005, 32'h00000005, 1, 32'h0, 5'b00100);
    add_row(4'd15, 32'hffffffff, 32'h0, 1, 32'h0, 5'b01000);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      expected_q.push_back(directed[i].known ? directed[i].res
                           : alu_predict(directed[i].op, directed[i].a, directed[i].b));
      send(directed[i].op, directed[i].a, directed[i].b, 1);
    end
    // pause until every expected result has come
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    for (int n = 0; n < N_RANDOM; n++) begin
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      a = rand_operand();
      b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
      expected_q.push_back(alu_predict(op, a, b));
      send(op, a, b, (n % 300) > 100);
    end
    in_tvalid <= 1'b0;
    sender_done <= 1'b1;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int k;
    out_tready = 1'b0;
    k = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      k++;
      if (k == 400) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      if ((k / 250) % 2 == 0) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 29) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // result checking
  always @(posedge clk) begin
    alu_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[DW+4:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %h gt%b lt%b eq%b dbz%b ovf%b, got %h %b%b%b%b%b",
                     want.value, want.gt, want.lt, want.eq, want.dbz, want.ovf,
                     got.value, got.gt, got.lt, got.eq, got.dbz, got.ovf);
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    mismatches = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (sender_done && expected_q.size() == 0) begin
        repeat (LATENCY * 2) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_mul.sv
hw/rtl/fpa_div.sv
hw/rtl/fixed_point_q24_8_alu_top.sv
bench/fixed_point_q24_8_alu_top_test.sv
